// ----- hdl/tfl_pkg.sv -----
// ----------------------------------------------------------------------------
// tfl_pkg
// Shared widths, operation codes and transfer types for the TLB with
// first-in-first-out / least-recently-used replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfl_pkg;

    // default table size
    localparam int TFL_ENTRIES = 16;

    // field widths
    localparam int OP_W    = 3;
    localparam int ID_W    = 16;
    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 16;
    localparam int IDX_W   = 4;
    localparam int TOT_W   = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLACE    = 3'd2;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH      = 3'd4;

    // replacement policy values
    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    // request item
    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [ID_W-1:0]    proc_id;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic [ID_W-1:0]    old_proc_id;
        logic [PAGE_W-1:0]  old_page;
    } t_in_item;

    // result item
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   entry_index;
        logic [FRAME_W-1:0] frame_out;
        logic               evicted;
        logic [ID_W-1:0]    victim_proc_id;
        logic [PAGE_W-1:0]  victim_page;
        logic [FRAME_W-1:0] victim_frame;
        logic [TOT_W-1:0]   hit_total;
        logic [TOT_W-1:0]   miss_total;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hdl/tfl_entry_ram.sv -----
// ----------------------------------------------------------------------------
// tfl_entry_ram
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfl_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 56,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tlb_fifo_lru_replacement.sv -----
// ----------------------------------------------------------------------------
// tlb_fifo_lru_replacement
// Fully associative TLB keyed by process id and page, with a first-in-
// first-out or least-recently-used replacement order and hit/miss counters.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_in  (t_in_item)
//  result    out        o_out_valid / i_out_stall o_out (t_out_item)
//  config    in         i_cfg_wr_en               i_cfg_wr_data (policy)
//
//  An operation runs a search pass and a decision step, plus a second pass
//  when the ranks are rewritten (insert, replace hit, LRU hit).
//  Each pass reads the entry store one entry per cycle.
//  Reset empties the table through per-entry flags at once; no clearing pass.
//  A finished result waits in the output register while the next request is
//  taken; a stalled output holds the sequencer only at its final step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlb_fifo_lru_replacement
    import tfl_pkg::*;
#(
    parameter int ENTRIES = TFL_ENTRIES
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_wr_en,
    input  wire logic      i_cfg_wr_data,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]    owner;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic [IW-1:0]      rank;
    } t_entry;

    localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
    localparam logic [IW-1:0] RANK_TOP = IW'(ENTRIES - 1);

    // control
    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_policy;
    t_in_item           r_item;
    logic               r_rd_ok;
    logic [IW-1:0]      r_rd_idx;
    logic [ENTRIES-1:0] r_live;
    logic [ENTRIES-1:0] r_wr;
    logic [TOT_W-1:0]   r_hit_cnt, r_miss_cnt;
    logic               r_out_vld;
    t_out_item          r_out;
    t_out_item          r_res;

    // search results
    logic               r_m_found;
    logic [IW-1:0]      r_m_idx;
    logic [IW-1:0]      r_m_rank;
    logic [ID_W-1:0]    r_m_owner;
    logic [PAGE_W-1:0]  r_m_page;
    logic [FRAME_W-1:0] r_m_frame;
    logic               r_f_found;
    logic [IW-1:0]      r_f_idx;
    logic [IW-1:0]      r_f_rank;
    logic [IW-1:0]      r_z_idx;
    logic [ID_W-1:0]    r_z_owner;
    logic [PAGE_W-1:0]  r_z_page;
    logic [FRAME_W-1:0] r_z_frame;

    // rank update target
    logic [IW-1:0]      r_tgt_idx;
    logic [IW-1:0]      r_tgt_rank;
    logic               r_tgt_new;

    logic               in_xfer, out_free;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    t_entry             rd_data;
    logic               wr_en;
    t_entry             wr_data;
    logic [ID_W-1:0]    eff_owner;
    logic [IW-1:0]      eff_rank;
    logic [ID_W-1:0]    key_id;
    logic [PAGE_W-1:0]  key_pg;
    logic               is_match, is_free, is_zero;
    logic               dec_upd;
    logic [IW-1:0]      dec_tgt_idx;
    logic [IW-1:0]      dec_tgt_rank;
    t_out_item          dec_res;
    t_out_item          done_res;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // entry store walk: one read per cycle; in the update pass each entry is written back in the next cycle
    assign rd_en   = ((r_state == S_SCAN) || (r_state == S_UPD)) && (r_cnt != CNT_END);
    assign rd_addr = r_cnt[IW-1:0];
    assign wr_en   = (r_state == S_UPD) && r_rd_ok;

    tfl_entry_ram #(
        .DEPTH (ENTRIES),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_rd_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // owner reads free until written after reset or flush; rank reads index until written
    assign eff_owner = r_live[r_rd_idx] ? rd_data.owner : '0;
    assign eff_rank  = r_wr[r_rd_idx] ? rd_data.rank : r_rd_idx;

    // search key
    assign key_id = (r_item.opcode == OP_REPLACE) ? r_item.old_proc_id : r_item.proc_id;
    assign key_pg = (r_item.opcode == OP_REPLACE) ? r_item.old_page : r_item.page;

    assign is_match = r_rd_ok && (key_id != '0) && (eff_owner == key_id)
                      && (rd_data.page == key_pg);
    assign is_free  = r_rd_ok && (eff_owner == '0);
    assign is_zero  = r_rd_ok && (eff_rank == '0);

    // rank rewrite data
    always_comb begin
        wr_data = rd_data;
        if (r_rd_idx == r_tgt_idx) begin
            if (r_tgt_new) begin
                wr_data.owner = r_item.proc_id;
                wr_data.page  = r_item.page;
                wr_data.frame = r_item.frame;
            end
            wr_data.rank = RANK_TOP;
        end else if (eff_rank > r_tgt_rank) begin
            wr_data.rank = eff_rank - IW'(1);
        end else begin
            wr_data.rank = eff_rank;
        end
    end

    // decision after the search pass
    always_comb begin
        dec_res      = '0;
        dec_upd      = 1'b0;
        dec_tgt_idx  = r_m_idx;
        dec_tgt_rank = r_m_rank;
        case (r_item.opcode)
            OP_LOOKUP: begin
                if (r_m_found) begin
                    dec_res.found       = 1'b1;
                    dec_res.entry_index = IDX_W'(r_m_idx);
                    dec_res.frame_out   = r_m_frame;
                    dec_upd             = (r_policy == POL_LRU);
                end
            end
            OP_INSERT: begin
                dec_upd = 1'b1;
                if (r_f_found) begin
                    dec_tgt_idx  = r_f_idx;
                    dec_tgt_rank = r_f_rank;
                end else begin
                    dec_tgt_idx            = r_z_idx;
                    dec_tgt_rank           = '0;
                    dec_res.evicted        = 1'b1;
                    dec_res.victim_proc_id = r_z_owner;
                    dec_res.victim_page    = r_z_page;
                    dec_res.victim_frame   = r_z_frame;
                end
                dec_res.entry_index = IDX_W'(dec_tgt_idx);
            end
            OP_REPLACE: begin
                if (r_m_found) begin
                    dec_upd                = 1'b1;
                    dec_res.found          = 1'b1;
                    dec_res.entry_index    = IDX_W'(r_m_idx);
                    dec_res.evicted        = 1'b1;
                    dec_res.victim_proc_id = r_m_owner;
                    dec_res.victim_page    = r_m_page;
                    dec_res.victim_frame   = r_m_frame;
                end
            end
            OP_INVALIDATE: begin
                if (r_m_found) begin
                    dec_res.found       = 1'b1;
                    dec_res.entry_index = IDX_W'(r_m_idx);
                end
            end
            default: begin
            end
        endcase
    end

    // finished result with the current totals
    always_comb begin
        done_res            = r_res;
        done_res.hit_total  = r_hit_cnt;
        done_res.miss_total = r_miss_cnt;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (r_cnt == CNT_END) begin
                    n_state = S_DEC;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DEC: begin
                n_cnt   = '0;
                n_state = dec_upd ? S_UPD : S_DONE;
            end
            S_UPD: begin
                if (r_cnt == CNT_END) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_policy   <= POL_FIFO;
            r_rd_ok    <= 1'b0;
            r_live     <= '0;
            r_wr       <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rd_ok <= rd_en;
            if (i_cfg_wr_en) begin
                r_policy <= i_cfg_wr_data;
            end
            // rank rewrite marks the entry's stored rank as valid
            if (wr_en) begin
                r_wr[r_rd_idx] <= 1'b1;
            end
            // occupancy flags and counters at the decision step
            if (r_state == S_DEC) begin
                case (r_item.opcode)
                    OP_LOOKUP: begin
                        if (r_m_found) begin
                            r_hit_cnt <= r_hit_cnt + TOT_W'(1);
                        end else begin
                            r_miss_cnt <= r_miss_cnt + TOT_W'(1);
                        end
                    end
                    OP_INSERT: begin
                        r_live[dec_tgt_idx] <= 1'b1;
                    end
                    OP_REPLACE: begin
                        if (r_m_found) begin
                            r_live[r_m_idx] <= 1'b1;
                        end
                    end
                    OP_INVALIDATE: begin
                        if (r_m_found) begin
                            r_live[r_m_idx] <= 1'b0;
                        end
                    end
                    OP_FLUSH: begin
                        r_live <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            // output register
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;
        if (in_xfer) begin
            r_item    <= i_in;
            r_m_found <= 1'b0;
            r_f_found <= 1'b0;
        end
        // search pass: first match, first free entry, rank-0 entry
        if (r_state == S_SCAN) begin
            if (is_match && !r_m_found) begin
                r_m_found <= 1'b1;
                r_m_idx   <= r_rd_idx;
                r_m_rank  <= eff_rank;
                r_m_owner <= eff_owner;
                r_m_page  <= rd_data.page;
                r_m_frame <= rd_data.frame;
            end
            if (is_free && !r_f_found) begin
                r_f_found <= 1'b1;
                r_f_idx   <= r_rd_idx;
                r_f_rank  <= eff_rank;
            end
            if (is_zero) begin
                r_z_idx   <= r_rd_idx;
                r_z_owner <= eff_owner;
                r_z_page  <= rd_data.page;
                r_z_frame <= rd_data.frame;
            end
        end
        if (r_state == S_DEC) begin
            r_res      <= dec_res;
            r_tgt_idx  <= dec_tgt_idx;
            r_tgt_rank <= dec_tgt_rank;
            r_tgt_new  <= (r_item.opcode != OP_LOOKUP);
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out <= done_res;
        end
    end

    // walk counter never runs past the table
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_END)
        else $error("entry walk counter out of range");

    // a lookup bumps exactly one of the two counters
    a_lookup_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) && (r_item.opcode == OP_LOOKUP)
        |=> (r_hit_cnt + r_miss_cnt) == ($past(r_hit_cnt) + $past(r_miss_cnt) + TOT_W'(1)))
        else $error("lookup did not count once");

    // other operations leave the counters alone
    a_other_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) && (r_item.opcode != OP_LOOKUP)
        |=> $stable(r_hit_cnt) && $stable(r_miss_cnt))
        else $error("counter changed on a non-lookup");

    // the target entry is written back as newest
    a_tgt_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && (r_rd_idx == r_tgt_idx) |-> wr_data.rank == RANK_TOP)
        else $error("target entry not made newest");

endmodule

`default_nettype wire
